@@ design/sthc_pkg.sv @@
// sthc_pkg: types and fixed constants for the stick-to-color block.
// Holds the sample and color words, the cell link type and the arctangent table.
// No dependencies.
package sthc_pkg;

    localparam int CW           = 23;   // cordic vector width
    localparam int ZW           = 16;   // accumulated angle width
    localparam int AW           = 18;   // channel angle arithmetic width
    localparam int CORDIC_STEPS = 14;
    localparam int SQRT_STEPS   = 16;
    localparam int CHAN_STAGES  = 6;

    localparam logic signed [ZW-1:0] ANG_HALF_PI = 16'sd12868;

    localparam logic signed [AW-1:0] ANG_PI        = 18'sd25736;
    localparam logic signed [AW-1:0] ANG_TWO_PI    = 18'sd51472;
    localparam logic signed [AW-1:0] ANG_THIRD     = 18'sd17157;
    localparam logic signed [AW-1:0] ANG_TWO_THIRD = 18'sd34315;
    localparam logic signed [AW-1:0] PHASE_RED     = 18'sd0;
    localparam logic signed [AW-1:0] PHASE_GREEN   = ANG_THIRD;
    localparam logic signed [AW-1:0] PHASE_BLUE    = ANG_TWO_THIRD;

    localparam logic [30:0] LEVEL_ROUND = 31'd17157;
    localparam logic [15:0] LEVEL_DIV   = 16'd34314;
    localparam logic [16:0] LEVEL_RECIP = 17'd125166;   // floor(2^32 / 34314)
    localparam logic signed [AW-1:0] MAG_OFFSET = 18'sd16384;
    localparam logic signed [AW-1:0] SUM_SAT    = 18'sd54400;
    localparam logic [19:0] TENTH_RECIP = 20'd838861;   // ceil(2^23 / 10)
    localparam logic [15:0] FULL_SCALE  = 16'd65280;

    typedef struct packed {
        logic [7:0] stick_x;
        logic [7:0] stick_y;
    } sample_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } color_t;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [ZW-1:0] z;
        logic                 zero;
        logic [31:0]          rem;
        logic [31:0]          root;
    } work_t;

    typedef struct packed {
        logic  valid;
        work_t work;
    } link_t;

    function automatic logic signed [ZW-1:0] atan_step(input int idx);
        logic signed [ZW-1:0] a;
        case (idx)
            0:       a = 16'sd6434;
            1:       a = 16'sd3798;
            2:       a = 16'sd2007;
            3:       a = 16'sd1019;
            4:       a = 16'sd511;
            5:       a = 16'sd256;
            6:       a = 16'sd128;
            7:       a = 16'sd64;
            8:       a = 16'sd32;
            9:       a = 16'sd16;
            10:      a = 16'sd8;
            11:      a = 16'sd4;
            12:      a = 16'sd2;
            13:      a = 16'sd1;
            default: a = 16'sd0;
        endcase
        return a;
    endfunction

endpackage

@@ design/sthc_cell.sv @@
// sthc_cell: one cell of the angle and magnitude chain.
// Does one square-root bit per cycle, plus one cordic micro-rotation in the first
// 14 cells; uses sthc_pkg.
module sthc_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sthc_pkg::link_t feed,
    output sthc_pkg::link_t pass
);

    localparam logic [31:0] RootBit = 32'(1) << (30 - 2 * STEP);

    logic                           vld_reg;
    sthc_pkg::work_t                work_reg;
    sthc_pkg::work_t                work_next;
    logic signed [sthc_pkg::CW-1:0] dx;
    logic signed [sthc_pkg::CW-1:0] dy;
    logic [31:0]                    trial;

    always_comb
    begin
        work_next = feed.work;
        dx        = feed.work.cy >>> STEP;
        dy        = feed.work.cx >>> STEP;
        if (STEP < sthc_pkg::CORDIC_STEPS)
        begin
            if (!feed.work.cy[sthc_pkg::CW-1])
            begin
                work_next.cx = feed.work.cx + dx;
                work_next.cy = feed.work.cy - dy;
                work_next.z  = feed.work.z + sthc_pkg::atan_step(STEP);
            end
            else
            begin
                work_next.cx = feed.work.cx - dx;
                work_next.cy = feed.work.cy + dy;
                work_next.z  = feed.work.z - sthc_pkg::atan_step(STEP);
            end
        end
        trial = feed.work.root + RootBit;
        if (feed.work.rem >= trial)
        begin
            work_next.rem  = feed.work.rem - trial;
            work_next.root = (feed.work.root >> 1) + RootBit;
        end
        else
        begin
            work_next.root = feed.work.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= feed.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign pass.valid = vld_reg;
    assign pass.work  = work_reg;

endmodule

@@ design/sthc_chan.sv @@
// sthc_chan: one color channel, from stick angle and magnitude to 8.8 level.
// Six register stages; uses sthc_pkg constants.
module sthc_chan (
    input  logic                           clk,
    input  logic signed [sthc_pkg::ZW-1:0] angle,
    input  logic [15:0]                    mag,
    input  logic signed [sthc_pkg::AW-1:0] phase,
    output logic [15:0]                    level
);

    logic signed [sthc_pkg::AW-1:0] v_raw;
    logic signed [sthc_pkg::AW-1:0] v_wrap;
    logic signed [sthc_pkg::AW-1:0] v_lim;
    logic signed [sthc_pkg::AW-1:0] t_full;
    logic [30:0]                    num_next;
    logic [30:0]                    num_reg;
    logic [15:0]                    mag0_reg;

    logic [47:0]                    prod_next;
    logic [47:0]                    prod_reg;
    logic [30:0]                    num1_reg;
    logic [15:0]                    mag1_reg;

    logic [15:0]                    q0;
    logic [31:0]                    back_next;
    logic [31:0]                    back_reg;
    logic [15:0]                    q0_reg;
    logic [30:0]                    num2_reg;
    logic [15:0]                    mag2_reg;

    logic [31:0]                    rem;
    logic [15:0]                    lvl;
    logic signed [sthc_pkg::AW-1:0] sum_next;
    logic signed [sthc_pkg::AW-1:0] sum_reg;

    logic [19:0]                    n2;
    logic [39:0]                    scl_next;
    logic [39:0]                    scl_reg;
    logic                           pos_reg;
    logic                           sat_reg;

    logic [15:0]                    level_next;
    logic [15:0]                    level_reg;

    always_comb
    begin
        v_raw = phase - sthc_pkg::AW'(angle);
        if (v_raw > sthc_pkg::ANG_TWO_PI)
        begin
            v_wrap = v_raw - sthc_pkg::ANG_TWO_PI;
        end
        else if (v_raw > sthc_pkg::ANG_PI)
        begin
            v_wrap = v_raw - sthc_pkg::ANG_PI;
        end
        else if (v_raw < -sthc_pkg::ANG_PI)
        begin
            v_wrap = v_raw + sthc_pkg::ANG_PI;
        end
        else
        begin
            v_wrap = v_raw;
        end
        v_lim    = (v_wrap > sthc_pkg::ANG_THIRD) ? '0 : v_wrap;
        t_full   = sthc_pkg::ANG_THIRD - v_lim;
        num_next = {t_full[15:0], 15'b0} + sthc_pkg::LEVEL_ROUND;
    end

    assign prod_next = {17'b0, num_reg} * {31'b0, sthc_pkg::LEVEL_RECIP};

    assign q0        = prod_reg[47:32];
    assign back_next = {16'b0, q0} * {16'b0, sthc_pkg::LEVEL_DIV};

    always_comb
    begin
        rem      = {1'b0, num2_reg} - back_reg;
        lvl      = q0_reg + ((rem >= {16'b0, sthc_pkg::LEVEL_DIV}) ? 16'd1 : 16'd0);
        sum_next = $signed({2'b0, lvl}) + $signed({2'b0, mag2_reg}) - sthc_pkg::MAG_OFFSET;
    end

    assign n2       = {3'b0, sum_reg[16:0]} * 20'd12 + 20'd5;
    assign scl_next = {20'b0, n2} * {20'b0, sthc_pkg::TENTH_RECIP};

    always_comb
    begin
        if (!pos_reg)
        begin
            level_next = '0;
        end
        else if (sat_reg)
        begin
            level_next = sthc_pkg::FULL_SCALE;
        end
        else
        begin
            level_next = scl_reg[38:23];
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        mag0_reg  <= mag;
        prod_reg  <= prod_next;
        num1_reg  <= num_reg;
        mag1_reg  <= mag0_reg;
        back_reg  <= back_next;
        q0_reg    <= q0;
        num2_reg  <= num1_reg;
        mag2_reg  <= mag1_reg;
        sum_reg   <= sum_next;
        scl_reg   <= scl_next;
        pos_reg   <= (sum_reg > 18'sd0);
        sat_reg   <= (sum_reg > sthc_pkg::SUM_SAT);
        level_reg <= level_next;
    end

    assign level = level_reg;

endmodule

@@ design/stick_to_hue_color.sv @@
// stick_to_hue_color: top level, analog stick sample to RGB color.
// Uses sthc_pkg, sthc_cell and sthc_chan.
//
// Usage:
//   Raise start with a sample word (stick_x, stick_y, raw bytes centred at 128).
//   The word is taken at every rising edge where start is high and busy is low.
//   busy stays low: a new sample word may be taken in every cycle.
//   The color word (red, green, blue, unsigned 8.8, 0.0 to 255.0) appears on
//   color for one cycle with done high, once its sample has passed the pipeline.
//   Pipeline: one input stage, a chain of 16 cells (one square-root bit each,
//   and one cordic micro-rotation in each of the first 14), and a six-stage
//   color pipe per channel.
//   Throughput: one word per cycle; color words leave in sample order.
//   The receiver cannot stall; done and color must be captured when shown.
//   Reset clears all valid bits; words in flight are dropped and no done
//   pulse follows until new samples are taken.
module stick_to_hue_color (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sthc_pkg::sample_t sample,
    output logic             done,
    output sthc_pkg::color_t  color
);

    logic signed [7:0]              x;
    logic signed [7:0]              y;
    logic [15:0]                    xx;
    logic [15:0]                    yy;
    logic [16:0]                    sq;
    logic signed [sthc_pkg::CW-1:0] cx0;
    logic signed [sthc_pkg::CW-1:0] cy0;
    sthc_pkg::work_t                head_next;
    sthc_pkg::work_t                head_reg;
    logic                           hvld_reg;
    sthc_pkg::link_t                chain [0:sthc_pkg::SQRT_STEPS];

    logic signed [sthc_pkg::ZW-1:0] angle;
    logic [15:0]                    mag;
    logic [sthc_pkg::CHAN_STAGES-1:0] vld_reg;
    logic [sthc_pkg::CHAN_STAGES-1:0] vld_next;
    logic [15:0]                    lvl_r;
    logic [15:0]                    lvl_g;
    logic [15:0]                    lvl_b;

    assign busy = 1'b0;

    always_comb
    begin
        x   = $signed({~sample.stick_x[7], sample.stick_x[6:0]});
        y   = $signed({~sample.stick_y[7], sample.stick_y[6:0]});
        xx  = x * x;
        yy  = y * y;
        sq  = {1'b0, xx} + {1'b0, yy};
        cx0 = sthc_pkg::CW'(y) <<< 12;
        cy0 = sthc_pkg::CW'(x) <<< 12;

        head_next.zero = (x == 8'sd0) && (y == 8'sd0);
        head_next.rem  = {sq[15:0], 16'b0};
        head_next.root = '0;
        head_next.cx   = cx0;
        head_next.cy   = cy0;
        head_next.z    = '0;
        if (cx0[sthc_pkg::CW-1])
        begin
            if (!cy0[sthc_pkg::CW-1])
            begin
                head_next.cx = cy0;
                head_next.cy = -cx0;
                head_next.z  = sthc_pkg::ANG_HALF_PI;
            end
            else
            begin
                head_next.cx = -cy0;
                head_next.cy = cx0;
                head_next.z  = -sthc_pkg::ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvld_reg <= 1'b0;
            vld_reg  <= '0;
        end
        else
        begin
            hvld_reg <= start && !busy;
            vld_reg  <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
    end

    assign chain[0].valid = hvld_reg;
    assign chain[0].work  = head_reg;

    for (genvar i = 0; i < sthc_pkg::SQRT_STEPS; i++)
    begin : g_cell
        sthc_cell #(
            .STEP(i)
        ) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .feed (chain[i]),
            .pass (chain[i+1])
        );
    end

    assign angle = chain[sthc_pkg::SQRT_STEPS].work.zero ? '0
                 : chain[sthc_pkg::SQRT_STEPS].work.z;
    assign mag   = chain[sthc_pkg::SQRT_STEPS].work.root[15:0];

    assign vld_next = {vld_reg[sthc_pkg::CHAN_STAGES-2:0],
                       chain[sthc_pkg::SQRT_STEPS].valid};

    sthc_chan u_red (
        .clk  (clk),
        .angle(angle),
        .mag  (mag),
        .phase(sthc_pkg::PHASE_RED),
        .level(lvl_r)
    );

    sthc_chan u_green (
        .clk  (clk),
        .angle(angle),
        .mag  (mag),
        .phase(sthc_pkg::PHASE_GREEN),
        .level(lvl_g)
    );

    sthc_chan u_blue (
        .clk  (clk),
        .angle(angle),
        .mag  (mag),
        .phase(sthc_pkg::PHASE_BLUE),
        .level(lvl_b)
    );

    assign done        = vld_reg[sthc_pkg::CHAN_STAGES-1];
    assign color.red   = lvl_r;
    assign color.green = lvl_g;
    assign color.blue  = lvl_b;

endmodule
